### design/dmsr_pkg.sv
// ----------------------------------------------------------------------------
// dmsr_pkg
// Shared types, codes and constants of the dual motor speed ramp core.
// ----------------------------------------------------------------------------
package dmsr_pkg;

   localparam int SPEED_W     = 16;
   localparam int UNIT_W      = 14;
   localparam int GRADE_W     = 3;
   localparam int STEP_W      = UNIT_W + GRADE_W;
   localparam int MV_W        = 16;
   localparam int KIND_W      = 2;
   localparam int SUPPLY_W    = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int TICK_DIVIDE_DEFAULT = 10;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RUN    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

   // supply alarm codes
   localparam logic [SUPPLY_W-1:0] SUPPLY_NORMAL = 2'd0;
   localparam logic [SUPPLY_W-1:0] SUPPLY_UNDER  = 2'd1;
   localparam logic [SUPPLY_W-1:0] SUPPLY_OVER   = 2'd2;

   localparam logic [MV_W-1:0] UNDER_MV = 16'd18500;
   localparam logic [MV_W-1:0] OVER_MV  = 16'd26500;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_SPEED     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_SPEED     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RAMP_UNIT     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPEED_GRADE_1 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SPEED_GRADE_2 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_RAMP_GRADE_1  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_RAMP_GRADE_2  = 3'd6;

   // floor(p / 7) == (p * RECIP_7) >> RECIP_SHIFT, exact for p < 2**19
   localparam int                PROD_W      = SPEED_W + GRADE_W;
   localparam int                RECIP_SHIFT = 22;
   localparam int                RECIP_W     = 20;
   localparam logic [RECIP_W-1:0] RECIP_7    = 20'd599187;

   // cycles the target pipeline needs after a register write
   localparam int                SETTLE_W      = 2;
   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              motor;
      logic              run;
      logic              direction;
      logic              fault_first;
      logic              fault_second;
      logic [MV_W-1:0]   supply_mv;
   } req_item_type;

   // packed so that the last field sits in the lowest bits
   typedef struct packed {
      logic [SUPPLY_W-1:0] supply_alarm;
      logic                alarm_second;
      logic                alarm_first;
      logic                running_second;
      logic                running_first;
      logic                dir_second;
      logic                dir_first;
      logic [SPEED_W-1:0]  compare_second;
      logic [SPEED_W-1:0]  compare_first;
   } rsp_item_type;

   typedef struct packed {
      logic [SPEED_W-1:0] target_speed;
      logic [STEP_W-1:0]  ramp_step;
   } chan_cfg_type;

endpackage

### design/dmsr_grade.sv
// ----------------------------------------------------------------------------
// dmsr_grade
// Derives each channel's target speed and ramp step from the registers.
// ----------------------------------------------------------------------------
module dmsr_grade (
   input  logic                            clock,
   input  logic [dmsr_pkg::SPEED_W-1:0]    min_speed,
   input  logic [dmsr_pkg::SPEED_W-1:0]    max_speed,
   input  logic [dmsr_pkg::UNIT_W-1:0]     ramp_unit,
   input  logic [dmsr_pkg::GRADE_W-1:0]    speed_grade [2],
   input  logic [dmsr_pkg::GRADE_W-1:0]    ramp_grade [2],
   output dmsr_pkg::chan_cfg_type          chan_cfg [2]
);
   import dmsr_pkg::*;

   logic [SPEED_W:0]           diff;
   logic                       diff_neg;
   logic [SPEED_W-1:0]         diff_mag;
   logic [PROD_W-1:0]          prod_in [2];
   logic [PROD_W-1:0]          prod_ff [2];
   logic                       neg_s1_ff;
   logic                       neg_s2_ff;
   logic [STEP_W-1:0]          step_in [2];
   logic [STEP_W-1:0]          step_ff [2];
   logic [PROD_W+RECIP_W-1:0]  recip_prod [2];
   logic [SPEED_W-1:0]         quot_in [2];
   logic [SPEED_W-1:0]         quot_ff [2];
   logic [SPEED_W-1:0]         target_in [2];
   logic [SPEED_W-1:0]         target_ff [2];

   assign diff     = {1'b0, max_speed} - {1'b0, min_speed};
   assign diff_neg = diff[SPEED_W];
   assign diff_mag = diff_neg ? SPEED_W'(-diff) : diff[SPEED_W-1:0];

   always_comb begin
      for (int ch = 0; ch < 2; ch++) begin
         prod_in[ch]    = PROD_W'(diff_mag * speed_grade[ch]);
         step_in[ch]    = STEP_W'(ramp_unit * ramp_grade[ch]);
         recip_prod[ch] = prod_ff[ch] * RECIP_7;
         quot_in[ch]    = recip_prod[ch][RECIP_SHIFT +: SPEED_W];
         // quotient truncates toward zero, so the sign goes on afterwards
         target_in[ch]  = neg_s2_ff ? (min_speed - quot_ff[ch])
                                    : (min_speed + quot_ff[ch]);
      end
   end

   always_ff @(posedge clock) begin
      neg_s1_ff <= diff_neg;
      neg_s2_ff <= neg_s1_ff;
      for (int ch = 0; ch < 2; ch++) begin
         prod_ff[ch]   <= prod_in[ch];
         step_ff[ch]   <= step_in[ch];
         quot_ff[ch]   <= quot_in[ch];
         target_ff[ch] <= target_in[ch];
      end
   end

   always_comb begin
      for (int ch = 0; ch < 2; ch++) begin
         chan_cfg[ch].target_speed = target_ff[ch];
         chan_cfg[ch].ramp_step    = step_ff[ch];
      end
   end

endmodule

### design/dmsr_ramp.sv
// ----------------------------------------------------------------------------
// dmsr_ramp
// One ramp step of a channel's compare value toward its target.
// ----------------------------------------------------------------------------
module dmsr_ramp (
   input  logic [dmsr_pkg::SPEED_W-1:0] current_speed,
   input  logic [dmsr_pkg::SPEED_W-1:0] target_speed,
   input  logic [dmsr_pkg::STEP_W-1:0]  ramp_step,
   input  logic [dmsr_pkg::SPEED_W-1:0] min_speed,
   output logic [dmsr_pkg::SPEED_W-1:0] next_speed
);
   import dmsr_pkg::*;

   logic [SPEED_W+1:0] up_sum;
   logic [SPEED_W+1:0] raised;
   logic [SPEED_W-1:0] lowered;

   assign up_sum = {2'b00, current_speed} + {1'b0, ramp_step};

   always_comb begin
      // acceleration starts from the minimum running speed
      raised = (current_speed < min_speed) ? {2'b00, min_speed} : up_sum;
      // deceleration drops to zero at or below the minimum
      if (current_speed <= min_speed) begin
         lowered = '0;
      end else if ({1'b0, current_speed} > ramp_step) begin
         lowered = current_speed - ramp_step[SPEED_W-1:0];
      end else begin
         lowered = '0;
      end

      priority if (current_speed == target_speed) begin
         next_speed = current_speed;
      end else if (ramp_step == '0) begin
         next_speed = target_speed;
      end else if (current_speed < target_speed) begin
         next_speed = (raised >= {2'b00, target_speed}) ? target_speed
                                                        : raised[SPEED_W-1:0];
      end else begin
         next_speed = (lowered <= target_speed) ? target_speed : lowered;
      end
   end

endmodule

### design/dmsr_state.sv
// ----------------------------------------------------------------------------
// dmsr_state
// Channel state, tick prescaler and fault latches; applies one item per
// advance and presents the updated state as the result.
// ----------------------------------------------------------------------------
module dmsr_state #(
   parameter int TICK_DIVIDE = dmsr_pkg::TICK_DIVIDE_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  dmsr_pkg::req_item_type        item,
   input  dmsr_pkg::chan_cfg_type        chan_cfg [2],
   input  logic [dmsr_pkg::SPEED_W-1:0]  min_speed,
   output dmsr_pkg::rsp_item_type        result
);
   import dmsr_pkg::*;

   localparam int PRESCALE_W = $clog2(TICK_DIVIDE + 1);
   localparam logic [PRESCALE_W-1:0] PRESCALE_LAST = PRESCALE_W'(TICK_DIVIDE);

   logic [SPEED_W-1:0]    current_ff [2];
   logic [SPEED_W-1:0]    current_in [2];
   logic [SPEED_W-1:0]    target_ff [2];
   logic [SPEED_W-1:0]    target_in [2];
   logic [SPEED_W-1:0]    ramp_next [2];
   logic [1:0]            run_ff;
   logic [1:0]            run_in;
   logic [1:0]            dir_ff;
   logic [1:0]            dir_in;
   logic [1:0]            fault_ff;
   logic [1:0]            fault_in;
   logic [SUPPLY_W-1:0]   supply_ff;
   logic [SUPPLY_W-1:0]   supply_in;
   logic [PRESCALE_W-1:0] prescale_ff;
   logic [PRESCALE_W-1:0] prescale_in;

   for (genvar ch = 0; ch < 2; ch++) begin : g_ramp
      dmsr_ramp u_ramp (
         .current_speed (current_ff[ch]),
         .target_speed  (target_ff[ch]),
         .ramp_step     (chan_cfg[ch].ramp_step),
         .min_speed     (min_speed),
         .next_speed    (ramp_next[ch])
      );
   end

   always_comb begin
      current_in  = current_ff;
      target_in   = target_ff;
      run_in      = run_ff;
      dir_in      = dir_ff;
      fault_in    = fault_ff;
      supply_in   = supply_ff;
      prescale_in = prescale_ff;

      unique case (item.kind)
         KIND_TICK: begin
            if (prescale_ff == PRESCALE_LAST) begin
               prescale_in = '0;
               current_in  = ramp_next;
            end else begin
               prescale_in = prescale_ff + 1'b1;
            end
         end
         KIND_RUN: begin
            dir_in[item.motor]    = item.direction;
            run_in[item.motor]    = item.run;
            target_in[item.motor] = item.run ? chan_cfg[item.motor].target_speed : '0;
         end
         KIND_STATUS: begin
            fault_in = {item.fault_second, item.fault_first};
            priority if (item.supply_mv < UNDER_MV) begin
               supply_in = SUPPLY_UNDER;
            end else if (item.supply_mv > OVER_MV) begin
               supply_in = SUPPLY_OVER;
            end else begin
               supply_in = SUPPLY_NORMAL;
            end
            // a channel's own fault or any supply alarm stops that running motor
            for (int ch = 0; ch < 2; ch++) begin
               if ((fault_in[ch] || supply_in != SUPPLY_NORMAL) && run_ff[ch]) begin
                  run_in[ch]    = 1'b0;
                  target_in[ch] = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff  <= '{default: '0};
         target_ff   <= '{default: '0};
         run_ff      <= '0;
         dir_ff      <= '0;
         fault_ff    <= '0;
         supply_ff   <= SUPPLY_NORMAL;
         prescale_ff <= '0;
      end else if (advance) begin
         current_ff  <= current_in;
         target_ff   <= target_in;
         run_ff      <= run_in;
         dir_ff      <= dir_in;
         fault_ff    <= fault_in;
         supply_ff   <= supply_in;
         prescale_ff <= prescale_in;
      end
   end

   always_comb begin
      result.compare_first  = current_in[0];
      result.compare_second = current_in[1];
      result.dir_first      = dir_in[0];
      result.dir_second     = dir_in[1];
      result.running_first  = run_in[0];
      result.running_second = run_in[1];
      result.alarm_first    = fault_in[0];
      result.alarm_second   = fault_in[1];
      result.supply_alarm   = supply_in;
   end

endmodule

### design/dual_motor_speed_ramp_core.sv
// ----------------------------------------------------------------------------
// dual_motor_speed_ramp_core
// Two-channel PWM compare ramp generator with run commands and fault latching.
// ----------------------------------------------------------------------------
// Accepts one item per clock while req_tready is high and returns one result
// for every item. An input register holds the item, and the state update and
// result are formed in one pass and captured in the output register, which
// drives rsp_tvalid. While a result waits on rsp_tready, one more item can
// enter the input register before req_tready drops. After reset and after
// every register write, req_tready stays low while the target-speed pipeline
// (subtract and grade multiply, multiply by the reciprocal of seven, add to
// the minimum) picks up the new values. Compare values move once every
// TICK_DIVIDE+1 tick items.
module dual_motor_speed_ramp_core #(
   parameter int TICK_DIVIDE = dmsr_pkg::TICK_DIVIDE_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // tdata: motor, run, direction, fault_first, fault_second, supply_mv[15:0]
   input  logic [23:0]                         req_tdata,
   // tuser: kind[1:0]
   input  logic [dmsr_pkg::KIND_W-1:0]         req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: compare_first[15:0], compare_second[15:0], dir_first, dir_second,
   //        running_first, running_second, alarm_first, alarm_second,
   //        supply_alarm[1:0]
   output logic [39:0]                         rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dmsr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dmsr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import dmsr_pkg::*;

   logic [SPEED_W-1:0]  min_speed_ff;
   logic [SPEED_W-1:0]  max_speed_ff;
   logic [UNIT_W-1:0]   ramp_unit_ff;
   logic [GRADE_W-1:0]  speed_grade_ff [2];
   logic [GRADE_W-1:0]  ramp_grade_ff [2];
   logic                csr_write;

   logic [SETTLE_W-1:0] settle_ff;
   logic [SETTLE_W-1:0] settle_in;

   req_item_type        req_item;
   req_item_type        item_ff;
   logic                item_valid_ff;
   logic                item_valid_in;
   logic                req_xfer;
   logic                advance;

   chan_cfg_type        chan_cfg [2];
   rsp_item_type        result;
   rsp_item_type        rsp_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   // register port
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_speed_ff   <= '0;
         max_speed_ff   <= '1;
         ramp_unit_ff   <= UNIT_W'(1);
         speed_grade_ff <= '{default: GRADE_W'(7)};
         ramp_grade_ff  <= '{default: GRADE_W'(2)};
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MIN_SPEED:     min_speed_ff      <= csr_wdata;
            REG_MAX_SPEED:     max_speed_ff      <= csr_wdata;
            REG_RAMP_UNIT:     ramp_unit_ff      <= csr_wdata[UNIT_W-1:0];
            REG_SPEED_GRADE_1: speed_grade_ff[0] <= csr_wdata[GRADE_W-1:0];
            REG_SPEED_GRADE_2: speed_grade_ff[1] <= csr_wdata[GRADE_W-1:0];
            REG_RAMP_GRADE_1:  ramp_grade_ff[0]  <= csr_wdata[GRADE_W-1:0];
            REG_RAMP_GRADE_2:  ramp_grade_ff[1]  <= csr_wdata[GRADE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (csr_write) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_CYCLES;
      end else begin
         settle_ff <= settle_in;
      end
   end

   dmsr_grade u_grade (
      .clock       (clock),
      .min_speed   (min_speed_ff),
      .max_speed   (max_speed_ff),
      .ramp_unit   (ramp_unit_ff),
      .speed_grade (speed_grade_ff),
      .ramp_grade  (ramp_grade_ff),
      .chan_cfg    (chan_cfg)
   );

   // input register
   always_comb begin
      req_item.kind         = req_tuser;
      req_item.motor        = req_tdata[0];
      req_item.run          = req_tdata[1];
      req_item.direction    = req_tdata[2];
      req_item.fault_first  = req_tdata[3];
      req_item.fault_second = req_tdata[4];
      req_item.supply_mv    = req_tdata[5 +: MV_W];
   end

   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (settle_ff == '0) && (!item_valid_ff || advance);
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      if (req_xfer) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff <= req_item;
      end
   end

   dmsr_state #(
      .TICK_DIVIDE (TICK_DIVIDE)
   ) u_state (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item_ff),
      .chan_cfg  (chan_cfg),
      .min_speed (min_speed_ff),
      .result    (result)
   );

   // output register
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

### test/dual_motor_speed_ramp_core_tb.sv
// ----------------------------------------------------------------------------
// dual_motor_speed_ramp_core_tb
// Self-checking bench for the two-channel speed ramp core. Ticks, run
// commands and status updates are streamed in bursts with random gaps while
// the result side stalls on its own pattern. Every result is checked field by
// field against a predicted copy of the ramp, command and fault state, under
// several register settings that include the extremes.
// ----------------------------------------------------------------------------
module dual_motor_speed_ramp_core_tb;
   import dmsr_pkg::*;

   localparam int TICK_DIV        = TICK_DIVIDE_DEFAULT;
   localparam int PHASES          = 5;
   localparam int ITEMS_PER_PHASE = 220;
   localparam int IDLE_LIMIT      = 2000;
   localparam int SETTLE          = 4;
   localparam int TAIL_CYCLES     = 8;
   localparam int MAX_PRINT       = 20;

   localparam logic [KIND_W-1:0]      KIND_SPARE = 2'd3;  // unused kind
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;  // past the register list

   typedef enum {RX_STEADY, RX_CHOPPY, RX_STALLS} rx_mode_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [23:0]            req_tdata  = '0;
   logic [KIND_W-1:0]      req_tuser  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [39:0]            rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // predicted registers
   logic [SPEED_W-1:0] cfg_min;
   logic [SPEED_W-1:0] cfg_max;
   logic [UNIT_W-1:0]  cfg_unit;
   logic [GRADE_W-1:0] cfg_speed_grade [2];
   logic [GRADE_W-1:0] cfg_ramp_grade  [2];

   // predicted channel and fault state
   logic [SPEED_W-1:0]  speed_now  [2];
   logic [SPEED_W-1:0]  speed_goal [2];
   logic                run_on      [2];
   logic                dir_now     [2];
   logic                fault_latch [2];
   logic [SUPPLY_W-1:0] supply_state;
   int                  prescale;

   rsp_item_type pending_status [$];
   rsp_item_type got_status;
   rsp_item_type want_status;

   int error_count     = 0;
   int results_checked = 0;
   int items_sent      = 0;
   int writes_done     = 0;
   int settings_used   = 0;
   int kind_count [4]  = '{0, 0, 0, 0};
   int burst_left      = 0;
   int quiet_cycles    = 0;

   rx_mode_type rx_mode    = RX_STEADY;
   int          mode_left  = 0;
   int          stall_left = 0;

   always #5 clock = ~clock;

   dual_motor_speed_ramp_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   task automatic clear_prediction();
      cfg_min            = '0;
      cfg_max            = 16'hFFFF;
      cfg_unit           = 14'd1;
      cfg_speed_grade[0] = 3'd7;
      cfg_speed_grade[1] = 3'd7;
      cfg_ramp_grade[0]  = 3'd2;
      cfg_ramp_grade[1]  = 3'd2;
      for (int i = 0; i < 2; i++) begin
         speed_now[i]   = '0;
         speed_goal[i]  = '0;
         run_on[i]      = 1'b0;
         dir_now[i]     = 1'b0;
         fault_latch[i] = 1'b0;
      end
      supply_state = SUPPLY_NORMAL;
      prescale     = 0;
   endtask

   function automatic void apply_register(input logic [CSR_INDEX_W-1:0] index,
                                          input logic [CSR_DATA_W-1:0] data);
      case (index)
         REG_MIN_SPEED:     cfg_min            = data;
         REG_MAX_SPEED:     cfg_max            = data;
         REG_RAMP_UNIT:     cfg_unit           = data[UNIT_W-1:0];
         REG_SPEED_GRADE_1: cfg_speed_grade[0] = data[GRADE_W-1:0];
         REG_SPEED_GRADE_2: cfg_speed_grade[1] = data[GRADE_W-1:0];
         REG_RAMP_GRADE_1:  cfg_ramp_grade[0]  = data[GRADE_W-1:0];
         REG_RAMP_GRADE_2:  cfg_ramp_grade[1]  = data[GRADE_W-1:0];
         default: ;
      endcase
   endfunction

   // linear interpolation between min and max, truncated toward zero
   function automatic logic [SPEED_W-1:0] grade_to_speed(input logic [GRADE_W-1:0] grade);
      int span;
      int part;
      span = int'(cfg_max) - int'(cfg_min);
      part = (span * int'(grade)) / 7;
      return SPEED_W'(int'(cfg_min) + part);
   endfunction

   function automatic void step_channel(input int ch);
      int cur;
      int goal;
      int step;
      cur  = speed_now[ch];
      goal = speed_goal[ch];
      step = int'(cfg_unit) * int'(cfg_ramp_grade[ch]);
      if (cur != goal) begin
         if (step == 0) begin
            cur = goal;
         end else if (cur < goal) begin
            // first step of an acceleration lands on the minimum speed
            if (cur < int'(cfg_min)) cur = cfg_min;
            else cur = cur + step;
            if (cur >= goal) cur = goal;
         end else begin
            if (cur <= int'(cfg_min)) cur = 0;
            else cur = (cur > step) ? cur - step : 0;
            if (cur <= goal) cur = goal;
         end
         speed_now[ch] = SPEED_W'(cur);
      end
   endfunction

   function automatic rsp_item_type predict_status(input req_item_type it);
      rsp_item_type r;
      int           i;
      case (it.kind)
         KIND_TICK: begin
            if (prescale < TICK_DIV) begin
               prescale++;
            end else begin
               step_channel(0);
               step_channel(1);
               prescale = 0;
            end
         end
         KIND_RUN: begin
            dir_now[it.motor]    = it.direction;
            run_on[it.motor]     = it.run;
            speed_goal[it.motor] = it.run ? grade_to_speed(cfg_speed_grade[it.motor]) : '0;
         end
         KIND_STATUS: begin
            fault_latch[0] = it.fault_first;
            fault_latch[1] = it.fault_second;
            if (it.supply_mv < UNDER_MV) supply_state = SUPPLY_UNDER;
            else if (it.supply_mv > OVER_MV) supply_state = SUPPLY_OVER;
            else supply_state = SUPPLY_NORMAL;
            for (i = 0; i < 2; i++) begin
               if ((fault_latch[i] || supply_state != SUPPLY_NORMAL) && run_on[i]) begin
                  run_on[i]     = 1'b0;
                  speed_goal[i] = '0;
               end
            end
         end
         default: ;
      endcase
      r.compare_first  = speed_now[0];
      r.compare_second = speed_now[1];
      r.dir_first      = dir_now[0];
      r.dir_second     = dir_now[1];
      r.running_first  = run_on[0];
      r.running_second = run_on[1];
      r.alarm_first    = fault_latch[0];
      r.alarm_second   = fault_latch[1];
      r.supply_alarm   = supply_state;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic req_item_type make_item(input logic [KIND_W-1:0] kind,
                                              input logic motor, input logic run,
                                              input logic direction, input logic fault_first,
                                              input logic fault_second,
                                              input logic [MV_W-1:0] supply_mv);
      req_item_type it;
      it.kind         = kind;
      it.motor        = motor;
      it.run          = run;
      it.direction    = direction;
      it.fault_first  = fault_first;
      it.fault_second = fault_second;
      it.supply_mv    = supply_mv;
      return it;
   endfunction

   // mostly ticks so ramps run to their targets, runs and clean status reports
   // in between, with some noisy status and the unused kind
   function automatic req_item_type random_item();
      req_item_type it;
      int           pick;
      it.motor        = $urandom_range(0, 1);
      it.run          = $urandom_range(0, 1);
      it.direction    = $urandom_range(0, 1);
      it.fault_first  = $urandom_range(0, 1);
      it.fault_second = $urandom_range(0, 1);
      it.supply_mv    = $urandom_range(0, 16'hFFFF);
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
         it.kind = KIND_TICK;
      end else if (pick < 86) begin
         it.kind = KIND_RUN;
         it.run  = ($urandom_range(0, 3) != 0);
      end else if (pick < 98) begin
         it.kind = KIND_STATUS;
         if ($urandom_range(0, 3) != 0) begin
            it.fault_first  = ($urandom_range(0, 7) == 0);
            it.fault_second = ($urandom_range(0, 7) == 0);
            it.supply_mv    = $urandom_range(UNDER_MV, OVER_MV);
         end
      end else begin
         it.kind = KIND_SPARE;
      end
      return it;
   endfunction

   task automatic send_item(input req_item_type it);
      int gap;
      @(negedge clock);
      req_tuser  <= it.kind;
      req_tdata  <= {3'b000, it.supply_mv, it.fault_second, it.fault_first,
                     it.direction, it.run, it.motor};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_status.push_back(predict_status(it));
      items_sent++;
      kind_count[it.kind]++;
      // bursts of random length; a quarter of them run on without a gap
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(0, 40);
      end
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_index <= index;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_register(index, data);
      writes_done++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_settings(input logic [CSR_DATA_W-1:0] min_speed,
                                input logic [CSR_DATA_W-1:0] max_speed,
                                input logic [CSR_DATA_W-1:0] unit,
                                input logic [CSR_DATA_W-1:0] grade_first,
                                input logic [CSR_DATA_W-1:0] grade_second,
                                input logic [CSR_DATA_W-1:0] ramp_first,
                                input logic [CSR_DATA_W-1:0] ramp_second);
      wait_for_results();
      write_register(REG_MIN_SPEED, min_speed);
      write_register(REG_MAX_SPEED, max_speed);
      write_register(REG_RAMP_UNIT, unit);
      write_register(REG_SPEED_GRADE_1, grade_first);
      write_register(REG_SPEED_GRADE_2, grade_second);
      write_register(REG_RAMP_GRADE_1, ramp_first);
      write_register(REG_RAMP_GRADE_2, ramp_second);
      settings_used++;
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_item_kinds();
      send_item(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000));
      send_item(make_item(KIND_RUN, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF));
      send_item(make_item(KIND_RUN, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000));
      send_item(make_item(KIND_SPARE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF));
      send_item(make_item(KIND_STATUS, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd20000));
   endtask

   // voltage thresholds on both sides, alarm latching, run while a fault is
   // latched, and a fault that stops only the motor it concerns
   task automatic test_supply_limits();
      send_item(make_item(KIND_STATUS, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, UNDER_MV - 16'd1));
      send_item(make_item(KIND_STATUS, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, UNDER_MV));
      send_item(make_item(KIND_STATUS, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, OVER_MV));
      send_item(make_item(KIND_STATUS, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, OVER_MV + 16'd1));
      send_item(make_item(KIND_STATUS, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 16'h0000));
      send_item(make_item(KIND_STATUS, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF));
      send_item(make_item(KIND_STATUS, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd20000));
      send_item(make_item(KIND_RUN, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0));
      send_item(make_item(KIND_RUN, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0));
      send_item(make_item(KIND_STATUS, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd20000));
      send_item(make_item(KIND_RUN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
   endtask

   // ramp grade zero: compare jumps to the target on the next ramp step
   task automatic test_zero_ramp_step();
      wait_for_results();
      write_register(REG_RAMP_GRADE_1, 16'd0);
      send_item(make_item(KIND_RUN, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0));
      repeat (TICK_DIV + 1) send_item(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0));
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: load_settings(16'd2000, 16'd60000, 16'd900, 16'd7, 16'd3, 16'd2, 16'd4);
            // largest step, ramp grade seven, and up steps past the 16-bit range
            1: load_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'd7, 16'd7, 16'd7, 16'd7);
            // maximum below minimum
            2: load_settings(16'hFFFF, 16'd0, 16'd3000, $urandom_range(0, 7),
                             $urandom_range(0, 7), 16'd1, 16'd5);
            3: load_settings($urandom_range(0, 8000), $urandom_range(30000, 65535),
                             $urandom_range(1, 16383), $urandom_range(0, 7),
                             $urandom_range(0, 7), 16'd0, 16'd0);
            default: begin
               load_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535));
               write_register(REG_UNUSED, $urandom_range(0, 65535));
            end
         endcase
         repeat (ITEMS_PER_PHASE) send_item(random_item());
      end
   endtask

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINT)
         $display("mismatch at result %0d: %s", results_checked, what);
   endtask

   task automatic check_field(input string name, input logic [SPEED_W-1:0] got,
                              input logic [SPEED_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_status.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_tdata));
         end else begin
            want_status = pending_status.pop_front();
            got_status  = rsp_item_type'(rsp_tdata);
            check_field("compare_first", got_status.compare_first, want_status.compare_first);
            check_field("compare_second", got_status.compare_second,
                        want_status.compare_second);
            check_field("dir_first", got_status.dir_first, want_status.dir_first);
            check_field("dir_second", got_status.dir_second, want_status.dir_second);
            check_field("running_first", got_status.running_first, want_status.running_first);
            check_field("running_second", got_status.running_second,
                        want_status.running_second);
            check_field("alarm_first", got_status.alarm_first, want_status.alarm_first);
            check_field("alarm_second", got_status.alarm_second, want_status.alarm_second);
            check_field("supply_alarm", got_status.supply_alarm, want_status.supply_alarm);
            results_checked++;
         end
      end
   end

   // result-side stalls: steady, choppy, or rare long holds
   always @(negedge clock) begin
      if (mode_left == 0) begin
         rx_mode   = rx_mode_type'($urandom_range(0, 2));
         mode_left = $urandom_range(50, 300);
      end else begin
         mode_left--;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_STEADY: rsp_tready <= 1'b1;
            RX_CHOPPY: rsp_tready <= ($urandom_range(0, 9) < 7);
            default: begin
               if ($urandom_range(0, 15) == 0) begin
                  stall_left = $urandom_range(1, 30);
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("no transfer for %0d cycles", IDLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      clear_prediction();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_item_kinds();
      test_supply_limits();
      test_zero_ramp_step();
      test_random_phases();

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d items (%0d ticks, %0d commands, %0d status, %0d unused kind), %0d writes",
               items_sent, kind_count[KIND_TICK], kind_count[KIND_RUN],
               kind_count[KIND_STATUS], kind_count[KIND_SPARE], writes_done);
      $display("%0d register settings, %0d results checked, %0d mismatches",
               settings_used, results_checked, error_count);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
